### rtl/core/klex_pkg.sv
// klex_pkg: token codes, symbol tables, reserved-word table and shared types
// for the keyword/symbol lexer. No dependencies.
package klex_pkg;

   // token codes
   localparam logic [5:0] CODE_ILLEGAL = 6'd0;
   localparam logic [5:0] CODE_SEMI    = 6'd12;
   localparam logic [5:0] CODE_COMMA   = 6'd13;
   localparam logic [5:0] CODE_ASSIGN  = 6'd14;
   localparam logic [5:0] CODE_NOT     = 6'd15;
   localparam logic [5:0] CODE_LBRACK  = 6'd16;
   localparam logic [5:0] CODE_RBRACK  = 6'd17;
   localparam logic [5:0] CODE_AND     = 6'd18;
   localparam logic [5:0] CODE_OR      = 6'd19;
   localparam logic [5:0] CODE_LPAREN  = 6'd20;
   localparam logic [5:0] CODE_RPAREN  = 6'd21;
   localparam logic [5:0] CODE_PLUS    = 6'd22;
   localparam logic [5:0] CODE_MINUS   = 6'd23;
   localparam logic [5:0] CODE_STAR    = 6'd24;
   localparam logic [5:0] CODE_NEQ     = 6'd25;
   localparam logic [5:0] CODE_EQ      = 6'd26;
   localparam logic [5:0] CODE_LT      = 6'd27;
   localparam logic [5:0] CODE_GT      = 6'd28;
   localparam logic [5:0] CODE_LE      = 6'd29;
   localparam logic [5:0] CODE_GE      = 6'd30;
   localparam logic [5:0] CODE_INT     = 6'd31;
   localparam logic [5:0] CODE_ID      = 6'd32;
   localparam logic [5:0] CODE_EOF     = 6'd33;

   // pending symbol characters
   localparam logic [2:0] PEND_NONE = 3'd0;
   localparam logic [2:0] PEND_BANG = 3'd1;
   localparam logic [2:0] PEND_EQ   = 3'd2;
   localparam logic [2:0] PEND_LT   = 3'd3;
   localparam logic [2:0] PEND_GT   = 3'd4;
   localparam logic [2:0] PEND_AMP  = 3'd5;
   localparam logic [2:0] PEND_BAR  = 3'd6;

   // segment class flag bits
   localparam int FLAG_DIGITS  = 0;
   localparam int FLAG_IDOK    = 1;
   localparam int FLAG_SEENDIG = 2;

   localparam int          WORD_CHARS  = 8;
   localparam int          NUM_RES     = 11;
   localparam int          ID_CHARS_DEFAULT = 8;
   localparam int          QUEUE_DEPTH = 4;
   localparam logic [30:0] INT_MAX31   = 31'h7FFF_FFFF;

   // reserved words, first character in the low byte
   localparam logic [63:0] RES_TEXT [NUM_RES] = '{
      64'h006d_6172_676f_7270,
      64'h0000_006e_6967_6562,
      64'h0000_0000_0064_6e65,
      64'h0000_0000_0074_6e69,
      64'h0000_0000_0000_6669,
      64'h0000_0000_6e65_6874,
      64'h0000_0000_6573_6c65,
      64'h0000_0065_6c69_6877,
      64'h0000_0000_706f_6f6c,
      64'h0000_0000_6461_6572,
      64'h0000_0065_7469_7277
   };
   localparam logic [7:0] RES_LEN [NUM_RES] = '{
      8'd7, 8'd5, 8'd3, 8'd3, 8'd2, 8'd4, 8'd4, 8'd5, 8'd4, 8'd4, 8'd5
   };

   typedef struct packed {
      logic [5:0]  code;
      logic [30:0] value;
      logic [63:0] text;
      logic [7:0]  length;
   } token_type;

   // all tokens caused by one input word
   typedef struct packed {
      logic [1:0]            count;
      token_type [2:0]       tok;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // low bytes kept for a word of n characters
   function automatic logic [63:0] res_mask(input logic [7:0] n);
      logic [63:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (8'(k) < n) m[8*k +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [7:0] pend_char(input logic [2:0] p);
      logic [7:0] r;
      case (p)
         PEND_BANG: r = 8'h21;
         PEND_EQ:   r = 8'h3D;
         PEND_LT:   r = 8'h3C;
         PEND_GT:   r = 8'h3E;
         PEND_AMP:  r = 8'h26;
         PEND_BAR:  r = 8'h7C;
         default:   r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] pend_single(input logic [2:0] p);
      logic [5:0] r;
      case (p)
         PEND_BANG: r = CODE_NOT;
         PEND_EQ:   r = CODE_ASSIGN;
         PEND_LT:   r = CODE_LT;
         PEND_GT:   r = CODE_GT;
         default:   r = CODE_ILLEGAL;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] pend_double(input logic [2:0] p);
      logic [5:0] r;
      case (p)
         PEND_BANG: r = CODE_NEQ;
         PEND_EQ:   r = CODE_EQ;
         PEND_LT:   r = CODE_LE;
         PEND_GT:   r = CODE_GE;
         PEND_AMP:  r = CODE_AND;
         PEND_BAR:  r = CODE_OR;
         default:   r = CODE_ILLEGAL;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] pend_of(input logic [7:0] c);
      logic [2:0] r;
      unique case (c)
         8'h21:   r = PEND_BANG;
         8'h3D:   r = PEND_EQ;
         8'h3C:   r = PEND_LT;
         8'h3E:   r = PEND_GT;
         8'h26:   r = PEND_AMP;
         8'h7C:   r = PEND_BAR;
         default: r = PEND_NONE;
      endcase
      return r;
   endfunction

   // single-character symbol code, CODE_ILLEGAL when none
   function automatic logic [5:0] single_of(input logic [7:0] c);
      logic [5:0] r;
      unique case (c)
         8'h3B:   r = CODE_SEMI;
         8'h2C:   r = CODE_COMMA;
         8'h5B:   r = CODE_LBRACK;
         8'h5D:   r = CODE_RBRACK;
         8'h28:   r = CODE_LPAREN;
         8'h29:   r = CODE_RPAREN;
         8'h2B:   r = CODE_PLUS;
         8'h2D:   r = CODE_MINUS;
         8'h2A:   r = CODE_STAR;
         default: r = CODE_ILLEGAL;
      endcase
      return r;
   endfunction

   function automatic token_type make_tok(input logic [5:0] code, input logic [7:0] len);
      token_type t;
      t.code   = code;
      t.value  = '0;
      t.text   = '0;
      t.length = len;
      return t;
   endfunction

   function automatic record_type push_tok(input record_type r, input token_type t);
      record_type o;
      o = r;
      if (r.count != 2'd3) begin
         o.tok[r.count] = t;
         o.count        = r.count + 2'd1;
      end
      return o;
   endfunction

endpackage

### rtl/core/klex_front.sv
// klex_front: takes one character a cycle while the queue has room, keeps the
// segment state and builds the record of tokens each word causes. Depends on klex_pkg.
module klex_front
   import klex_pkg::*;
#(
   parameter int ID_CHARS = ID_CHARS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_char_code,
   input  logic             req_end_of_input,
   input  queue_status_type q_status,
   output logic             q_push,
   output record_type       q_rec
);

   logic [63:0] chars_ff, chars_in;
   logic [7:0]  len_ff, len_in;
   logic [30:0] acc_ff, acc_in;
   logic [2:0]  flags_ff, flags_in;
   logic [2:0]  pend_ff, pend_in;
   logic        halt_ff, halt_in;
   logic        fire;
   record_type  rec;

   assign req_stall = q_status.full;
   assign fire      = req_valid && !req_stall;
   assign q_push    = fire && (rec.count != 2'd0);
   assign q_rec     = rec;

   // next segment state and token record for the word on the input
   always_comb begin
      logic [7:0]  c;
      logic [7:0]  pc;
      logic        amp, dbl_hit, amp_add, ws;
      logic [63:0] chars_e;
      logic [7:0]  len_e;
      logic [2:0]  flags_e;
      logic        f_valid, f_res, f_illegal;
      logic [5:0]  res_code;
      token_type   f_tok;
      logic [5:0]  sc;
      logic [2:0]  pk;
      logic [34:0] prod;
      logic        is_dig, is_up;

      c  = req_char_code;
      pc = pend_char(pend_ff);
      amp = (pend_ff == PEND_AMP) || (pend_ff == PEND_BAR);
      dbl_hit = !req_end_of_input && (pend_ff != PEND_NONE) &&
                (amp ? (c == pc) : (c == 8'h3D));
      amp_add = amp && !dbl_hit;
      ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
      sc = single_of(c);
      pk = pend_of(c);

      // segment with a lone ampersand or bar appended
      chars_e = chars_ff;
      len_e   = len_ff;
      flags_e = flags_ff;
      if (amp_add) begin
         if (len_ff < 8'd8) chars_e[8*len_ff[2:0] +: 8] = pc;
         if (len_ff != 8'hFF) len_e = len_ff + 8'd1;
         flags_e[FLAG_DIGITS] = 1'b0;
         flags_e[FLAG_IDOK]   = 1'b0;
      end

      // classify the segment as it would be flushed
      f_res    = 1'b0;
      res_code = CODE_ILLEGAL;
      for (int i = 0; i < NUM_RES; i++) begin
         if ((len_e == RES_LEN[i]) &&
             (((chars_e ^ RES_TEXT[i]) & res_mask(RES_LEN[i])) == 64'd0)) begin
            f_res    = 1'b1;
            res_code = 6'(i + 1);
         end
      end
      f_valid = (len_e != 8'd0);
      f_tok   = make_tok(CODE_ILLEGAL, len_e);
      if (f_res) begin
         f_tok.code = res_code;
      end else if (flags_e[FLAG_DIGITS]) begin
         f_tok.code  = CODE_INT;
         f_tok.value = acc_ff;
      end else if (flags_e[FLAG_IDOK]) begin
         f_tok.code = CODE_ID;
         for (int k = 0; k < 8; k++) begin
            if ((k < ID_CHARS) && (8'(k) < len_e)) f_tok.text[8*k +: 8] = chars_e[8*k +: 8];
         end
      end
      f_illegal = f_valid && (f_tok.code == CODE_ILLEGAL);

      // defaults: segment as extended, nothing emitted
      rec       = '0;
      chars_in  = chars_e;
      len_in    = len_e;
      acc_in    = acc_ff;
      flags_in  = flags_e;
      pend_in   = PEND_NONE;
      halt_in   = halt_ff;

      // appending the new character
      is_dig = (c >= 8'h30) && (c <= 8'h39);
      is_up  = (c >= 8'h41) && (c <= 8'h5A);
      prod   = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + 35'(c - 8'h30);

      if (halt_ff) begin
         chars_in = chars_ff;
         len_in   = len_ff;
         flags_in = flags_ff;
         pend_in  = pend_ff;
      end else if (req_end_of_input) begin
         if ((pend_ff != PEND_NONE) && !amp) rec = push_tok(rec, make_tok(pend_single(pend_ff), 8'd1));
         if (f_valid) rec = push_tok(rec, f_tok);
         if (f_illegal) halt_in = 1'b1;
         else rec = push_tok(rec, make_tok(CODE_EOF, 8'd0));
         len_in   = '0;
         acc_in   = '0;
         flags_in = 3'b011;
      end else if (dbl_hit) begin
         if (amp) begin
            if (f_valid) rec = push_tok(rec, f_tok);
            if (f_illegal) halt_in = 1'b1;
            else rec = push_tok(rec, make_tok(pend_double(pend_ff), 8'd2));
            len_in   = '0;
            acc_in   = '0;
            flags_in = 3'b011;
         end else begin
            rec = push_tok(rec, make_tok(pend_double(pend_ff), 8'd2));
         end
      end else begin
         if ((pend_ff != PEND_NONE) && !amp) rec = push_tok(rec, make_tok(pend_single(pend_ff), 8'd1));
         if (ws || (sc != CODE_ILLEGAL) || ((pk != PEND_NONE) && (pk < PEND_AMP))) begin
            if (f_valid) rec = push_tok(rec, f_tok);
            if (f_illegal) halt_in = 1'b1;
            else if (sc != CODE_ILLEGAL) rec = push_tok(rec, make_tok(sc, 8'd1));
            else if (!ws) pend_in = pk;
            len_in   = '0;
            acc_in   = '0;
            flags_in = 3'b011;
         end else if (pk != PEND_NONE) begin
            pend_in = pk;
         end else begin
            if (len_e < 8'd8) chars_in[8*len_e[2:0] +: 8] = c;
            if (len_e != 8'hFF) len_in = len_e + 8'd1;
            if (is_dig) begin
               acc_in = (prod > {4'd0, INT_MAX31}) ? INT_MAX31 : prod[30:0];
               if (len_e == 8'd0) flags_in[FLAG_IDOK] = 1'b0;
               flags_in[FLAG_SEENDIG] = 1'b1;
            end else if (is_up) begin
               flags_in[FLAG_DIGITS] = 1'b0;
               if (flags_e[FLAG_SEENDIG]) flags_in[FLAG_IDOK] = 1'b0;
            end else begin
               flags_in[FLAG_DIGITS] = 1'b0;
               flags_in[FLAG_IDOK]   = 1'b0;
            end
         end
      end
   end

   // segment text, no reset
   always_ff @(posedge clock) begin
      if (fire) chars_ff <= chars_in;
   end

   // segment control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         acc_ff   <= '0;
         flags_ff <= 3'b011;
         pend_ff  <= PEND_NONE;
         halt_ff  <= 1'b0;
      end else if (fire) begin
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         flags_ff <= flags_in;
         pend_ff  <= pend_in;
         halt_ff  <= halt_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !q_push) else $error("word pushed while halted");
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt released without reset");
   a_cmp_pend_empty: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != PEND_NONE) && (pend_ff < PEND_AMP) |-> (len_ff == 8'd0))
      else $error("comparison symbol pending over a live segment");

endmodule

### rtl/core/klex_queue.sv
// klex_queue: short queue of token records between front and back.
// Depends on klex_pkg.
module klex_queue
   import klex_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  record_type       wr_rec,
   input  logic             pop,
   output record_type       rd_rec,
   output queue_status_type status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   record_type    mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_rec       = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= wr_rec;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= PW'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH);
         if (pop)  rd_ptr_ff <= PW'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH);
         if (push && !pop)      count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full)) else $error("queue overflow");

endmodule

### rtl/core/klex_back.sv
// klex_back: takes records from the queue and hands out their tokens one
// word at a time on the result channel. Depends on klex_pkg.
module klex_back
   import klex_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  record_type       q_rec,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [5:0]       rsp_token_code,
   output logic [30:0]      rsp_int_value,
   output logic [63:0]      rsp_id_text,
   output logic [7:0]       rsp_token_length,
   output logic             rsp_last_of_run
);

   record_type cur_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic       take, last;
   token_type  tok;

   assign take  = valid_ff && !rsp_stall;
   assign last  = (idx_ff == (cur_ff.count - 2'd1));
   assign q_pop = !q_status.empty && (!valid_ff || (take && last));

   // token selection
   assign tok              = cur_ff.tok[idx_ff];
   assign rsp_valid        = valid_ff;
   assign rsp_token_code   = tok.code;
   assign rsp_int_value    = tok.value;
   assign rsp_id_text      = tok.text;
   assign rsp_token_length = tok.length;
   assign rsp_last_of_run  = last;

   // record payload
   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_rec;
   end

   // position within the record
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take && last) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   a_idx_in_record: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.count != 2'd0) && (idx_ff < cur_ff.count))
      else $error("token index beyond record");

endmodule

### rtl/core/keyword_symbol_lexer.sv
// keyword_symbol_lexer: top level, front classifier, record queue and
// token issue stage. Depends on klex_pkg, klex_front, klex_queue, klex_back.
//
// Usage: the req channel carries one source character a word (req_char_code)
// or an end-of-text marker (req_end_of_input). The rsp channel carries one
// token a word: code, saturated integer value, first identifier characters,
// length, and rsp_last_of_run on the last token an input word caused.
// Throughput is one character a cycle and one token a cycle unless rsp_stall
// is set; the front takes a character each cycle while the four-record queue
// has room, so bursts of up to three tokens from one character are absorbed.
// Tokens pass the queue and the issue stage's record register. When the
// receiver stalls, the queue fills and req_stall rises only once it is full.
// An illegal segment gives code 0 and the block stays silent until reset.
// Reset is synchronous: it empties the queue, clears the segment and any
// pending symbol, and lifts the halt. There is no clearing pass.
module keyword_symbol_lexer
   import klex_pkg::*;
#(
   parameter int ID_CHARS = ID_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_code,
   output logic [30:0] rsp_int_value,
   output logic [63:0] rsp_id_text,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_last_of_run
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   record_type       wr_rec, rd_rec;

   klex_front #(.ID_CHARS(ID_CHARS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_rec            (wr_rec)
   );

   klex_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_rec (wr_rec),
      .pop    (q_pop),
      .rd_rec (rd_rec),
      .status (q_status)
   );

   klex_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_rec            (rd_rec),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_code   (rsp_token_code),
      .rsp_int_value    (rsp_int_value),
      .rsp_id_text      (rsp_id_text),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
